// ===== sv/bsc_pkg.sv =====
// Shared types, constants and keystream functions for the byte stream cipher.
`timescale 1ns / 1ps
`default_nettype none

package bsc_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned CFG_IDX_W   = 2;

    localparam logic [BYTE_W-1:0] KEY_RESET = 8'b1011_0010;
    localparam logic [BYTE_W-1:0] CTR_RESET = 8'b0010_1000;

    // Register indexes on the config channel
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_KEY     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_COUNTER = 2'd1;

    localparam logic [BYTE_W-1:0] MASK_EVEN = 8'h55;
    localparam logic [BYTE_W-1:0] MASK_ODD  = 8'hAA;
    localparam logic [BYTE_W-1:0] MASK_ALL  = 8'hFF;

    typedef struct packed {
        logic [BYTE_W-1:0] initial_key;
        logic [BYTE_W-1:0] initial_counter;
    } bsc_cfg_t;

    // In-place scramble, bit 7 down to bit 0; lower bits see already-updated
    // upper bits, so this is a short dependent chain.
    function automatic logic [BYTE_W-1:0] scramble(input logic [BYTE_W-1:0] ctr,
                                                   input logic [BYTE_W-1:0] key);
        logic [BYTE_W-1:0] c;
        logic [2:0]        other;
        c = ctr;
        for (int i = BYTE_W - 1; i >= 0; i--) begin
            other = key[i] ? 3'(i + 1) : 3'(i + 2);
            c[i]  = c[i] ^ c[other];
        end
        return c;
    endfunction

    // v mod 9 via reciprocal: floor(v*57/512) is exact for 8-bit v
    function automatic logic [3:0] mod9(input logic [BYTE_W-1:0] v);
        logic [13:0] prod;
        logic [4:0]  quo;
        logic [8:0]  rem;
        prod = 14'(v) * 14'd57;
        quo  = prod[13:9];
        rem  = 9'(v) - 9'(quo) * 9'd9;
        return rem[3:0];
    endfunction

    function automatic logic [BYTE_W-1:0] sel_mask(input logic [BYTE_W-1:0] ctr);
        logic [3:0] r;
        r = mod9(ctr);
        if (r < 4'd3) begin
            return MASK_EVEN;
        end else if (r < 4'd6) begin
            return MASK_ODD;
        end
        return MASK_ALL;
    endfunction

endpackage

`default_nettype wire

// ===== sv/byte_stream_cipher.sv =====
// Byte stream cipher top level: input register, transform, output register.
//
// Usage:
//   Requests enter on the s_ channel: s_tdata carries the byte, s_tuser the
//   restart flag, which reloads key and counter from the configuration
//   registers before that byte. Each request yields exactly one result byte
//   on the m_ channel. Encryption and decryption are the same operation.
//   The config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes
//   index 0 = initial key, index 1 = initial counter; other indexes are
//   ignored. Writes take effect at the next restart; write only
//   while the block holds no request in flight.
//   Path: input register, then the result register behind the combinational
//   scramble and mask logic; m_tvalid comes from the result register.
//   Throughput: one byte per cycle while m_tready is held high.
//   Reset (aresetn low, synchronous) empties both stages and loads key 178,
//   counter 40. When the receiver stalls, the result register holds its
//   byte, the input register fills, and s_tready drops until m_tready rises.
`timescale 1ns / 1ps
`default_nettype none

module byte_stream_cipher (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [bsc_pkg::BYTE_W-1:0]    s_tdata,   // [7:0] data_in
    input  wire logic                          s_tuser,   // [0] restart
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [bsc_pkg::BYTE_W-1:0]         m_tdata,   // [7:0] data_out
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [bsc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bsc_pkg::BYTE_W-1:0]    cfg_data
);
    import bsc_pkg::*;

    bsc_cfg_t          cfg;
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_data_reg;
    logic              in_restart_reg;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_data_reg;
    logic [BYTE_W-1:0] xform_data;
    logic              out_load;
    logic              step;

    assign out_load = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && out_load;
    assign s_tready = !in_valid_reg || out_load;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    bsc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_out   (cfg)
    );

    bsc_xform u_xform (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .step     (step),
        .restart  (in_restart_reg),
        .data_in  (in_data_reg),
        .data_out (xform_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_load) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg    <= s_tdata;
            in_restart_reg <= s_tuser;
        end
        if (step) begin
            out_data_reg <= xform_data;
        end
    end

    a_step_fills_out: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> m_tvalid)
        else $error("processed request did not reach the result register");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("empty input stage refused a request");

    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (!s_tready) |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("backpressure without both stages full");

endmodule

`default_nettype wire

// ===== sv/bsc_cfg_regs.sv =====
// Configuration register file: initial key and initial counter.
`timescale 1ns / 1ps
`default_nettype none

module bsc_cfg_regs (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [bsc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bsc_pkg::BYTE_W-1:0]    cfg_data,
    output bsc_pkg::bsc_cfg_t                  cfg_out
);
    import bsc_pkg::*;

    bsc_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg_out   = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.initial_key     <= KEY_RESET;
            cfg_reg.initial_counter <= CTR_RESET;
        end else if (cfg_valid) begin
            // unknown indexes are dropped
            if (cfg_index == REG_INITIAL_KEY) begin
                cfg_reg.initial_key <= cfg_data;
            end else if (cfg_index == REG_INITIAL_COUNTER) begin
                cfg_reg.initial_counter <= cfg_data;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/bsc_xform.sv =====
// Running key/counter state and the per-byte transform.
`timescale 1ns / 1ps
`default_nettype none

module bsc_xform (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire bsc_pkg::bsc_cfg_t          cfg,
    input  wire logic                       step,
    input  wire logic                       restart,
    input  wire logic [bsc_pkg::BYTE_W-1:0] data_in,
    output logic [bsc_pkg::BYTE_W-1:0]      data_out
);
    import bsc_pkg::*;

    logic [BYTE_W-1:0] counter_reg, counter_next;
    logic [BYTE_W-1:0] key_reg,     key_next;
    logic [BYTE_W-1:0] ctr_base,    key_base;

    always_comb begin
        ctr_base     = restart ? cfg.initial_counter : counter_reg;
        key_base     = restart ? cfg.initial_key     : key_reg;
        counter_next = scramble(ctr_base, key_base) + BYTE_W'(1);
        key_next     = key_base + BYTE_W'(1);
        data_out     = data_in ^ (counter_next & sel_mask(counter_next));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            counter_reg <= CTR_RESET;
            key_reg     <= KEY_RESET;
        end else if (step) begin
            counter_reg <= counter_next;
            key_reg     <= key_next;
        end
    end

    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !step |=> ($stable(counter_reg) && $stable(key_reg)))
        else $error("keystream state moved without a request");

    a_key_incr: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && !restart) |=> (key_reg == $past(key_reg) + BYTE_W'(1)))
        else $error("key did not advance by one");

    a_key_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && restart) |=> (key_reg == $past(cfg.initial_key) + BYTE_W'(1)))
        else $error("restart did not reload the key");

endmodule

`default_nettype wire
